// ===== rtl/artb_pkg.sv =====
// Shared types and constants for the auto-reload timer bank.
// Used by artb_cell, artb_ctrl and auto_reload_timer_bank; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package artb_pkg;

   localparam int SLOTS       = 16;
   localparam int SLOT_W      = 4;
   localparam int OCC_W       = 5;
   localparam int MAX_RESULTS = 16;

   // byte address of the capacity register
   localparam logic [2:0] ADDR_CAPACITY = 3'd0;

   typedef enum logic [2:0] {
      KIND_CREATE = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_PAUSE  = 3'd2,
      KIND_RESUME = 3'd3,
      KIND_TICK   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_NOSLOT = 2'd2
   } status_type;

   // operation broadcast to every cell in the row
   typedef enum logic [2:0] {
      COP_HOLD,
      COP_CREATE,
      COP_DELETE,
      COP_RUN,
      COP_SUB,
      COP_RELOAD
   } cop_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_CHECK,
      CS_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      cop_type            op;
      logic [SLOT_W-1:0]  target;
      logic [31:0]        period;
      logic               reload;
      logic               run;
      logic [15:0]        tag;
      logic [31:0]        delta;
   } cell_ctl_type;

   typedef struct packed {
      logic [31:0] reload_value;
      logic [31:0] count;
      logic        periodic;
      logic        running;
      logic [15:0] tag;
   } cell_data_type;

endpackage

`default_nettype wire

// ===== rtl/auto_reload_timer_bank.sv =====
// Timing: create, delete, pause, resume and unknown words give their result in the next
// cycle. A tick counts down all slots in the cycle it is taken, then walks the occupied
// slots one per cycle in slot order, stalling while an expiry must move out and the result
// port is held off (a deleted one-shot timer is replaced by its neighbor and visited again
// at the same slot), then closes in the flush state once the result port is free.
// The limit of creatable slots is min(capacity_in_use, 16); it resets to 16.
// Top level: row of artb_cell slots, configuration register and artb_ctrl. Depends on artb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module auto_reload_timer_bank import artb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [31:0] req_period,
   input  wire logic        req_reload,
   input  wire logic        req_start_now,
   input  wire logic [15:0] req_tag,
   input  wire logic [3:0]  req_slot,
   input  wire logic [31:0] req_delta,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_result_slot,
   output logic             rsp_fired,
   output logic [15:0]      rsp_fired_tag,
   output logic             rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [OCC_W-1:0]  cap_ff;
   cell_ctl_type      cell_ctl;
   cell_data_type     cells [SLOTS];
   cell_data_type     neighbors [SLOTS];
   logic [SLOT_W-1:0] sel_idx;
   cell_data_type     sel_data;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= OCC_W'(SLOTS);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_CAPACITY) begin
         cap_ff <= csr_pwdata[OCC_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_CAPACITY) ? {27'd0, cap_ff} : 32'd0;

   // row of slots, each fed by its upper neighbor (the top slot by itself)
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == SLOTS - 1) begin : g_end
         assign neighbors[i] = cells[i];
      end else begin : g_mid
         assign neighbors[i] = cells[i+1];
      end
      artb_cell u_cell (
         .clock     (clock),
         .idx       (SLOT_W'(i)),
         .ctl       (cell_ctl),
         .next_data (neighbors[i]),
         .data      (cells[i])
      );
   end

   // pick the slot under the walk pointer
   assign sel_data = cells[sel_idx];

   artb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_period      (req_period),
      .req_reload      (req_reload),
      .req_start_now   (req_start_now),
      .req_tag         (req_tag),
      .req_slot        (req_slot),
      .req_delta       (req_delta),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot),
      .rsp_fired       (rsp_fired),
      .rsp_fired_tag   (rsp_fired_tag),
      .rsp_last        (rsp_last),
      .capacity        (cap_ff),
      .sel_data        (sel_data),
      .sel_idx         (sel_idx),
      .cell_ctl        (cell_ctl)
   );

endmodule

`default_nettype wire

// ===== rtl/artb_cell.sv =====
// One timer slot of the row: holds its timer and takes its neighbor's word on a delete.
// Depends on artb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module artb_cell import artb_pkg::*; (
   input  wire logic              clock,
   input  wire logic [SLOT_W-1:0] idx,
   input  wire cell_ctl_type      ctl,
   input  wire cell_data_type     next_data,
   output cell_data_type          data
);

   cell_data_type data_ff, data_in;

   // decode the broadcast operation against this slot's position
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         COP_CREATE: begin
            if (idx == ctl.target) begin
               data_in.reload_value = ctl.period;
               data_in.count        = ctl.period;
               data_in.periodic     = ctl.reload;
               data_in.running      = ctl.run;
               data_in.tag          = ctl.tag;
            end
         end
         COP_DELETE: begin
            if (idx >= ctl.target) data_in = next_data;
         end
         COP_RUN: begin
            if (idx == ctl.target) data_in.running = ctl.run;
         end
         COP_SUB: begin
            if (data_ff.running && data_ff.count != 32'd0) begin
               data_in.count = (data_ff.count > ctl.delta) ? data_ff.count - ctl.delta
                                                           : 32'd0;
            end
         end
         COP_RELOAD: begin
            if (idx == ctl.target) data_in.count = data_ff.reload_value;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/artb_ctrl.sv =====
// Sequencer of the timer bank: decodes words, walks the slots after a tick,
// owns the result register. Depends on artb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module artb_ctrl import artb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_kind,
   input  wire logic [31:0]       req_period,
   input  wire logic              req_reload,
   input  wire logic              req_start_now,
   input  wire logic [15:0]       req_tag,
   input  wire logic [3:0]        req_slot,
   input  wire logic [31:0]       req_delta,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [3:0]             rsp_result_slot,
   output logic                   rsp_fired,
   output logic [15:0]            rsp_fired_tag,
   output logic                   rsp_last,
   input  wire logic [OCC_W-1:0]  capacity,
   input  wire cell_data_type     sel_data,
   output logic [SLOT_W-1:0]      sel_idx,
   output cell_ctl_type           cell_ctl
);

   ctrl_state_type state_ff, state_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [OCC_W-1:0]  ptr_ff, ptr_in;
   logic [OCC_W-1:0]  n_ff, n_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [15:0]       pend_tag_ff, pend_tag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_fired_ff, rsp_fired_in;
   logic [15:0]       rsp_tag_ff, rsp_tag_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic [OCC_W-1:0]  limit;
   logic              take;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign limit    = (capacity > OCC_W'(SLOTS)) ? OCC_W'(SLOTS) : capacity;
   assign sel_idx  = ptr_ff[SLOT_W-1:0];

   // next state, cell command and result load
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_last_in   = rsp_last_ff;
      cell_ctl.op     = COP_HOLD;
      cell_ctl.target = req_slot;
      cell_ctl.period = req_period;
      cell_ctl.reload = req_reload;
      cell_ctl.run    = req_start_now;
      cell_ctl.tag    = req_tag;
      cell_ctl.delta  = req_delta;
      req_ready = 1'b0;
      take      = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_ready = out_free;
            take      = req_valid && out_free;
            if (take) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = '0;
               rsp_fired_in  = 1'b0;
               rsp_tag_in    = '0;
               rsp_last_in   = 1'b1;
               if (req_kind == KIND_CREATE) begin
                  if (occ_ff >= limit) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cell_ctl.op     = COP_CREATE;
                     cell_ctl.target = occ_ff[SLOT_W-1:0];
                     rsp_slot_in     = occ_ff[SLOT_W-1:0];
                     occ_in          = occ_ff + OCC_W'(1);
                  end
               end else if (req_kind inside {KIND_DELETE, KIND_PAUSE, KIND_RESUME}) begin
                  rsp_slot_in = req_slot;
                  if ({1'b0, req_slot} >= occ_ff) begin
                     rsp_status_in = ST_NOSLOT;
                  end else if (req_kind == KIND_DELETE) begin
                     cell_ctl.op = COP_DELETE;
                     occ_in      = occ_ff - OCC_W'(1);
                  end else begin
                     cell_ctl.op  = COP_RUN;
                     cell_ctl.run = (req_kind == KIND_RESUME);
                  end
               end else if (req_kind == KIND_TICK) begin
                  // count down every running cell now, report later from the walk
                  rsp_valid_in  = rsp_valid_ff && !rsp_ready;
                  cell_ctl.op   = COP_SUB;
                  ptr_in        = '0;
                  n_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = CS_CHECK;
               end
            end
         end
         CS_CHECK: begin
            if (ptr_ff >= occ_ff) begin
               state_in = CS_FLUSH;
            end else if (sel_data.count == 32'd0) begin
               // stall only when a result must move out and the register is busy
               if (!(n_ff < OCC_W'(MAX_RESULTS) && pend_valid_ff && !out_free)) begin
                  if (n_ff < OCC_W'(MAX_RESULTS)) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                        rsp_slot_in   = pend_slot_ff;
                        rsp_fired_in  = 1'b1;
                        rsp_tag_in    = pend_tag_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_slot_in  = ptr_ff[SLOT_W-1:0];
                     pend_tag_in   = sel_data.tag;
                     n_in          = n_ff + OCC_W'(1);
                  end
                  cell_ctl.target = ptr_ff[SLOT_W-1:0];
                  if (sel_data.periodic) begin
                     cell_ctl.op = COP_RELOAD;
                     ptr_in      = ptr_ff + OCC_W'(1);
                  end else begin
                     cell_ctl.op = COP_DELETE;
                     occ_in      = occ_ff - OCC_W'(1);
                  end
               end
            end else begin
               ptr_in = ptr_ff + OCC_W'(1);
            end
         end
         CS_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = pend_valid_ff ? pend_slot_ff : '0;
               rsp_fired_in  = pend_valid_ff;
               rsp_tag_in    = pend_valid_ff ? pend_tag_ff : '0;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CS_IDLE;
         occ_ff        <= '0;
         ptr_ff        <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         ptr_ff        <= ptr_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_slot_ff  <= pend_slot_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_slot = rsp_slot_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_fired_tag   = rsp_tag_ff;
   assign rsp_last        = rsp_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(SLOTS))
      else $error("occupancy beyond slot count");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == CS_IDLE)
      else $error("input taken while a tick is in progress");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_CHECK |-> ptr_ff <= occ_ff)
      else $error("walk pointer past occupied slots");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == CS_IDLE |-> !pend_valid_ff)
      else $error("held expiry left behind after a tick");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= OCC_W'(MAX_RESULTS))
      else $error("too many expiries reported");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for auto_reload_timer_bank: random and directed timer words,
// a scoreboard of expected result words from a behavioral timer table. Depends on artb_pkg.
`timescale 1ns / 1ps

module testbench import artb_pkg::*;;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] period;
      logic        reload;
      logic        start_now;
      logic [15:0] tag;
      logic [3:0]  slot;
      logic [31:0] delta;
   } timer_word_type;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  result_slot;
      logic        fired;
      logic [15:0] fired_tag;
      logic        last;
   } result_word_type;

   localparam int LIMIT_CYCLES = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic [31:0] req_period = '0;
   logic req_reload = 1'b0;
   logic req_start_now = 1'b0;
   logic [15:0] req_tag = '0;
   logic [3:0] req_slot = '0;
   logic [31:0] req_delta = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [3:0] rsp_result_slot;
   logic rsp_fired;
   logic [15:0] rsp_fired_tag;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   auto_reload_timer_bank dut (.*);

   always #5 clock = ~clock;

   // timer table mirror
   logic [31:0] tm_reload [SLOTS];
   logic [31:0] tm_count [SLOTS];
   logic tm_periodic [SLOTS];
   logic tm_running [SLOTS];
   logic [15:0] tm_tag [SLOTS];
   int tm_used = 0;
   int capacity = 16;

   timer_word_type pending_words[$];
   result_word_type expected_results[$];
   int mismatches = 0;
   int cycles = 0;
   bit calm = 1'b0;
   int send_gap = 0;
   int recv_gap = 0;

   function automatic result_word_type mk(logic [1:0] st, logic [3:0] sl, logic f,
                                          logic [15:0] tg);
      result_word_type r;
      r.status = st; r.result_slot = sl; r.fired = f; r.fired_tag = tg; r.last = 1'b0;
      return r;
   endfunction

   function automatic void drop_timer(int s);
      for (int i = s; i + 1 < tm_used; i++) begin
         tm_reload[i] = tm_reload[i+1]; tm_count[i] = tm_count[i+1];
         tm_periodic[i] = tm_periodic[i+1]; tm_running[i] = tm_running[i+1];
         tm_tag[i] = tm_tag[i+1];
      end
      tm_used--;
   endfunction

   // predict the result words of one accepted timer word
   function automatic void predict_timer_word(timer_word_type w);
      result_word_type r[$];
      int lim;
      int i;
      lim = capacity < SLOTS ? capacity : SLOTS;
      case (w.kind)
         KIND_CREATE: begin
            if (tm_used >= lim) r.push_back(mk(ST_FULL, 0, 0, 0));
            else begin
               tm_reload[tm_used] = w.period; tm_count[tm_used] = w.period;
               tm_periodic[tm_used] = w.reload; tm_running[tm_used] = w.start_now;
               tm_tag[tm_used] = w.tag;
               r.push_back(mk(ST_OK, tm_used[3:0], 0, 0));
               tm_used++;
            end
         end
         KIND_DELETE, KIND_PAUSE, KIND_RESUME: begin
            if (w.slot >= tm_used) r.push_back(mk(ST_NOSLOT, w.slot, 0, 0));
            else begin
               if (w.kind == KIND_DELETE) drop_timer(w.slot);
               else tm_running[w.slot] = (w.kind == KIND_RESUME);
               r.push_back(mk(ST_OK, w.slot, 0, 0));
            end
         end
         KIND_TICK: begin
            for (i = 0; i < tm_used; i++)
               if (tm_running[i] && tm_count[i] != 0)
                  tm_count[i] = tm_count[i] > w.delta ? tm_count[i] - w.delta : 32'd0;
            i = 0;
            while (i < tm_used) begin
               if (tm_count[i] == 0) begin
                  if (r.size() < MAX_RESULTS) r.push_back(mk(ST_OK, i[3:0], 1, tm_tag[i]));
                  tm_count[i] = tm_reload[i];
                  if (!tm_periodic[i]) begin
                     drop_timer(i);
                     continue;
                  end
               end
               i++;
            end
            if (r.size() == 0) r.push_back(mk(ST_OK, 0, 0, 0));
         end
         default: r.push_back(mk(ST_OK, 0, 0, 0));
      endcase
      r[r.size()-1].last = 1'b1;
      foreach (r[k]) expected_results.push_back(r[k]);
   endfunction

   // driver: present words from the pending queue with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_timer_word(pending_words.pop_front());
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(1, 14);
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               timer_word_type w;
               w = pending_words[0];
               req_valid <= 1'b1; req_kind <= w.kind; req_period <= w.period;
               req_reload <= w.reload; req_start_now <= w.start_now; req_tag <= w.tag;
               req_slot <= w.slot; req_delta <= w.delta;
            end else req_valid <= 1'b0;
         end
      end
   end

   // monitor: stall the result port at random, check every result word
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result word slot %0d", rsp_result_slot);
            end else begin
               result_word_type e;
               e = expected_results.pop_front();
               if ({rsp_status, rsp_result_slot, rsp_fired, rsp_fired_tag, rsp_last} !==
                   {e.status, e.result_slot, e.fired, e.fired_tag, e.last}) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp st=%0d sl=%0d f=%0d tag=%h last=%0d,",
                               " got st=%0d sl=%0d f=%0d tag=%h last=%0d"},
                        e.status, e.result_slot, e.fired, e.fired_tag, e.last, rsp_status,
                        rsp_result_slot, rsp_fired, rsp_fired_tag, rsp_last);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 14);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
      if (cycles >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic timer_word_type word_of(logic [2:0] k, logic [31:0] p, logic rl,
                                              logic sn, logic [15:0] tg, logic [3:0] sl,
                                              logic [31:0] d);
      timer_word_type w;
      w.kind = k; w.period = p; w.reload = rl; w.start_now = sn; w.tag = tg;
      w.slot = sl; w.delta = d;
      return w;
   endfunction

   function automatic logic [31:0] rand_count();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   function automatic timer_word_type rand_word();
      logic [2:0] k;
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) k = KIND_CREATE;
      else if (r < 42) k = KIND_DELETE;
      else if (r < 50) k = KIND_PAUSE;
      else if (r < 58) k = KIND_RESUME;
      else if (r < 96) k = KIND_TICK;
      else k = 3'($urandom_range(5, 7));
      return word_of(k, rand_count(), $urandom_range(0, 3) != 0, $urandom_range(0, 4) != 0,
                     16'($urandom), 4'($urandom_range(0, 15)), rand_count());
   endfunction

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // write the capacity register through the APB port
   task automatic write_capacity(logic [4:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= ADDR_CAPACITY;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      capacity = value;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_capacity(5'd16);
      // directed: fill past capacity, bad slots, pause/resume, zero and max periods
      pending_words.push_back(word_of(KIND_TICK, 0, 0, 0, 0, 0, 32'd5));
      pending_words.push_back(word_of(KIND_DELETE, 0, 0, 0, 0, 4'd15, 0));
      pending_words.push_back(word_of(KIND_CREATE, 32'd0, 1, 1, 16'hFFFF, 0, 0));
      pending_words.push_back(word_of(KIND_CREATE, 32'hFFFF_FFFF, 1, 0, 16'h0000, 0, 0));
      pending_words.push_back(word_of(KIND_CREATE, 32'd2, 0, 1, 16'hA5A5, 0, 0));
      pending_words.push_back(word_of(KIND_CREATE, 32'd0, 0, 0, 16'h5A5A, 0, 0));
      pending_words.push_back(word_of(KIND_PAUSE, 0, 0, 0, 0, 4'd2, 0));
      pending_words.push_back(word_of(KIND_RESUME, 0, 0, 0, 0, 4'd1, 0));
      pending_words.push_back(word_of(KIND_PAUSE, 0, 0, 0, 0, 4'd9, 0));
      pending_words.push_back(word_of(KIND_RESUME, 0, 0, 0, 0, 4'd9, 0));
      pending_words.push_back(word_of(KIND_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      pending_words.push_back(word_of(3'd5, 32'hFFFF_FFFF, 1, 1, 16'hFFFF, 4'hF, '1));
      pending_words.push_back(word_of(3'd7, 0, 0, 0, 0, 0, 0));
      pending_words.push_back(word_of(KIND_TICK, 0, 0, 0, 0, 0, 32'd0));
      pending_words.push_back(word_of(KIND_DELETE, 0, 0, 0, 0, 4'd0, 0));
      for (int i = 0; i < 17; i++)
         pending_words.push_back(word_of(KIND_CREATE, 0, i[0], 1, i[15:0], 0, 0));
      pending_words.push_back(word_of(KIND_TICK, 0, 0, 0, 0, 0, 32'd1));
      wait_drained();
      // random phases under different capacities, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_capacity(5'd0);
            1: write_capacity(5'd1);
            2: write_capacity(5'd31);
            3: write_capacity(5'd16);
            4: write_capacity(5'd5);
            default: write_capacity(5'($urandom_range(0, 31)));
         endcase
         if (ph == 5) calm = 1'b1;
         for (int i = 0; i < 70; i++) pending_words.push_back(rand_word());
         wait_drained();
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
